[hdl/two_stack_queue_unit_assert.svh]
// assertion macros used by the queue unit datapath
`ifndef TWO_STACK_QUEUE_UNIT_ASSERT_SVH
`define TWO_STACK_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define TSQ_ASSERT_NOW(lbl, clk, rst, cond, conseq, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define TSQ_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[hdl/tsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

   // storage geometry
   localparam int MAX_STACK_DEPTH = 256;
   localparam int WORD_BITS       = 32;
   localparam int ADDR_BITS       = $clog2(MAX_STACK_DEPTH);
   localparam int FILL_BITS       = ADDR_BITS + 1;

   // item field widths
   localparam int DATA_BITS  = 32;
   localparam int POS_BITS   = 9;
   localparam int COUNT_BITS = 10;
   localparam int CAP_BITS   = 9;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] CSR_CAPACITY_INDEX = '0;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(MAX_STACK_DEPTH);

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_READ    = 2'd2,
      CMD_COUNT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_XFER_RD,
      ST_XFER_WR,
      ST_EXEC,
      ST_REPLY
   } state_type;

   typedef struct packed {
      cmd_type                      command;
      logic signed [DATA_BITS-1:0]  push_value;
      logic        [POS_BITS-1:0]   position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0]  data_out;
      logic                         error;
      logic        [COUNT_BITS-1:0] element_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic xfer_rd;
      logic xfer_wr;
      logic push;
      logic pop;
      logic peek;
      logic emit;
      logic emit_err;
      logic emit_data;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type command;
      logic    in_full;
      logic    in_empty;
      logic    out_empty;
      logic    read_hit;
   } status_type;

endpackage

`default_nettype wire

[hdl/tsq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire tsq_pkg::status_type status,
   output tsq_pkg::ctrl_type        ctrl
);

   tsq_pkg::state_type state_ff;
   tsq_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tsq_pkg::ST_DECIDE;
            end
         end
         tsq_pkg::ST_DECIDE: begin
            unique case (status.command)
               tsq_pkg::CMD_ENQUEUE: begin
                  if (status.in_full && !status.out_empty) begin
                     state_in = tsq_pkg::ST_IDLE;
                  end else if (status.in_full) begin
                     state_in = tsq_pkg::ST_XFER_RD;
                  end else begin
                     state_in = tsq_pkg::ST_EXEC;
                  end
               end
               tsq_pkg::CMD_DEQUEUE: begin
                  if (status.in_empty && status.out_empty) begin
                     state_in = tsq_pkg::ST_IDLE;
                  end else if (status.out_empty) begin
                     state_in = tsq_pkg::ST_XFER_RD;
                  end else begin
                     state_in = tsq_pkg::ST_EXEC;
                  end
               end
               tsq_pkg::CMD_READ: begin
                  state_in = tsq_pkg::ST_EXEC;
               end
               default: begin
                  state_in = tsq_pkg::ST_IDLE;
               end
            endcase
         end
         tsq_pkg::ST_XFER_RD: begin
            state_in = tsq_pkg::ST_XFER_WR;
         end
         tsq_pkg::ST_XFER_WR: begin
            if (status.in_empty) begin
               state_in = tsq_pkg::ST_EXEC;
            end else begin
               state_in = tsq_pkg::ST_XFER_RD;
            end
         end
         tsq_pkg::ST_EXEC: begin
            if (status.command == tsq_pkg::CMD_READ && !status.read_hit) begin
               state_in = tsq_pkg::ST_IDLE;
            end else begin
               state_in = tsq_pkg::ST_REPLY;
            end
         end
         tsq_pkg::ST_REPLY: begin
            state_in = tsq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tsq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      ctrl = '0;
      busy = (state_ff != tsq_pkg::ST_IDLE);
      unique case (state_ff)
         tsq_pkg::ST_IDLE: begin
            ctrl.load = start;
         end
         tsq_pkg::ST_DECIDE: begin
            unique case (status.command)
               tsq_pkg::CMD_ENQUEUE: begin
                  if (status.in_full && !status.out_empty) begin
                     ctrl.emit     = 1'b1;
                     ctrl.emit_err = 1'b1;
                  end
               end
               tsq_pkg::CMD_DEQUEUE: begin
                  if (status.in_empty && status.out_empty) begin
                     ctrl.emit     = 1'b1;
                     ctrl.emit_err = 1'b1;
                  end
               end
               tsq_pkg::CMD_COUNT: begin
                  ctrl.emit = 1'b1;
               end
               default: begin
                  ctrl.emit = 1'b0;
               end
            endcase
         end
         tsq_pkg::ST_XFER_RD: begin
            ctrl.xfer_rd = 1'b1;
         end
         tsq_pkg::ST_XFER_WR: begin
            ctrl.xfer_wr = 1'b1;
         end
         tsq_pkg::ST_EXEC: begin
            unique case (status.command)
               tsq_pkg::CMD_ENQUEUE: begin
                  ctrl.push = 1'b1;
               end
               tsq_pkg::CMD_DEQUEUE: begin
                  ctrl.pop = 1'b1;
               end
               tsq_pkg::CMD_READ: begin
                  ctrl.peek     = status.read_hit;
                  ctrl.emit     = !status.read_hit;
                  ctrl.emit_err = !status.read_hit;
               end
               default: begin
                  ctrl.push = 1'b0;
               end
            endcase
         end
         tsq_pkg::ST_REPLY: begin
            ctrl.emit      = 1'b1;
            ctrl.emit_data = (status.command == tsq_pkg::CMD_DEQUEUE) ||
                             (status.command == tsq_pkg::CMD_READ);
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/tsq_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "two_stack_queue_unit_assert.svh"

module tsq_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tsq_pkg::req_type               req_item,
   input  wire logic [tsq_pkg::CAP_BITS-1:0]   capacity,
   input  wire tsq_pkg::ctrl_type              ctrl,
   output tsq_pkg::status_type                 status,
   output tsq_pkg::rsp_type                    rsp_item,
   output logic                                rsp_valid
);

   localparam int FB = tsq_pkg::FILL_BITS;
   localparam int AB = tsq_pkg::ADDR_BITS;
   localparam int CB = tsq_pkg::COUNT_BITS;
   localparam int WB = tsq_pkg::WORD_BITS;

   // stack storage
   logic [WB-1:0] in_mem  [tsq_pkg::MAX_STACK_DEPTH];
   logic [WB-1:0] out_mem [tsq_pkg::MAX_STACK_DEPTH];

   tsq_pkg::req_type req_ff;
   logic [FB-1:0]    in_fill_ff, in_fill_in;
   logic [FB-1:0]    out_fill_ff, out_fill_in;
   logic [WB-1:0]    in_rd_ff, out_rd_ff;
   logic             rd_src_in_ff;
   tsq_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic [FB-1:0] cap_eff;
   logic [CB-1:0] pos_ext, out_fill_ext, in_fill_ext;
   logic [CB-1:0] pos_in_rel;
   logic          hit_out, hit_in;
   logic [AB-1:0] in_raddr, out_raddr;
   logic          in_re, out_re;
   logic [FB-1:0] in_fill_dec, out_fill_dec;

   // capacity clamped to 1..MAX_STACK_DEPTH
   always_comb begin
      if (capacity == '0) begin
         cap_eff = FB'(1);
      end else if (tsq_pkg::COUNT_BITS'(capacity) > CB'(tsq_pkg::MAX_STACK_DEPTH)) begin
         cap_eff = FB'(tsq_pkg::MAX_STACK_DEPTH);
      end else begin
         cap_eff = FB'(capacity);
      end
   end

   // position decode: output stack holds the oldest words, top first
   assign pos_ext      = CB'(req_ff.position);
   assign out_fill_ext = CB'(out_fill_ff);
   assign in_fill_ext  = CB'(in_fill_ff);
   assign pos_in_rel   = pos_ext - out_fill_ext;
   assign hit_out      = pos_ext < out_fill_ext;
   assign hit_in       = !hit_out && (pos_in_rel < in_fill_ext);
   assign in_fill_dec  = in_fill_ff - FB'(1);
   assign out_fill_dec = out_fill_ff - FB'(1);

   always_comb begin
      status.command   = req_ff.command;
      status.in_full   = in_fill_ff >= cap_eff;
      status.in_empty  = in_fill_ff == '0;
      status.out_empty = out_fill_ff == '0;
      status.read_hit  = hit_out || hit_in;
   end

   // memory read addresses
   always_comb begin
      in_raddr  = ctrl.xfer_rd ? in_fill_dec[AB-1:0] : pos_in_rel[AB-1:0];
      in_re     = ctrl.xfer_rd || (ctrl.peek && !hit_out);
      out_raddr = ctrl.pop ? out_fill_dec[AB-1:0]
                           : AB'(out_fill_ext - pos_ext - CB'(1));
      out_re    = ctrl.pop || (ctrl.peek && hit_out);
   end

   // input stack memory
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         in_mem[in_fill_ff[AB-1:0]] <= WB'(req_ff.push_value);
      end
      if (in_re) begin
         in_rd_ff <= in_mem[in_raddr];
      end
   end

   // output stack memory
   always_ff @(posedge clock) begin
      if (ctrl.xfer_wr) begin
         out_mem[out_fill_ff[AB-1:0]] <= in_rd_ff;
      end
      if (out_re) begin
         out_rd_ff <= out_mem[out_raddr];
      end
   end

   // fill counters
   always_comb begin
      in_fill_in  = in_fill_ff;
      out_fill_in = out_fill_ff;
      if (ctrl.xfer_rd) begin
         in_fill_in = in_fill_dec;
      end else if (ctrl.push) begin
         in_fill_in = in_fill_ff + FB'(1);
      end
      if (ctrl.xfer_wr) begin
         out_fill_in = out_fill_ff + FB'(1);
      end else if (ctrl.pop) begin
         out_fill_in = out_fill_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_fill_ff  <= '0;
         out_fill_ff <= '0;
      end else begin
         in_fill_ff  <= in_fill_in;
         out_fill_ff <= out_fill_in;
      end
   end

   // request capture and read source
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_item;
      end
      if (in_re || out_re) begin
         rd_src_in_ff <= in_re;
      end
   end

   // result register
   always_comb begin
      rsp_in.data_out      = '0;
      rsp_in.error         = ctrl.emit_err;
      rsp_in.element_count = out_fill_ext + in_fill_ext;
      if (ctrl.emit_data) begin
         rsp_in.data_out = tsq_pkg::DATA_BITS'(rd_src_in_ff ? in_rd_ff : out_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit;
      end
      if (ctrl.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `TSQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `TSQ_ASSERT_NOW(a_push_room, clock, reset, ctrl.push, in_fill_ff < FB'(tsq_pkg::MAX_STACK_DEPTH), "push into full input stack")
   `TSQ_ASSERT_NOW(a_pop_nonempty, clock, reset, ctrl.pop, out_fill_ff != '0, "pop from empty output stack")
   `TSQ_ASSERT_NOW(a_xfer_src, clock, reset, ctrl.xfer_rd, in_fill_ff != '0, "transfer from empty input stack")
   `TSQ_ASSERT_NEXT(a_xfer_pair, clock, reset, ctrl.xfer_rd, ctrl.xfer_wr && !rsp_valid_ff, "transfer read not followed by write")

endmodule

`default_nettype wire

[hdl/two_stack_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Queue of 32-bit signed words kept in an input stack and an output stack, each up
// to stack_capacity words. An item is taken when start is high and busy is low, and
// each item gives exactly one result, shown for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take the result in that cycle. Count and refused
// commands are answered from the decide state, a read of a missing position from
// the execute state, and enqueue, dequeue and hit reads from the reply state; busy
// falls in the cycle the result shows. When an enqueue finds the input stack full
// with the output stack empty, or a dequeue finds the output stack empty, the whole
// input stack is first moved over, each word read and then written. No clearing
// pass follows reset. stack_capacity (byte address 0) must be written only while
// busy is low; the block does not enforce this. 0 acts as 1, values over 256 as 256.
module two_stack_queue_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire tsq_pkg::req_type                    req_item,
   output tsq_pkg::rsp_type                         rsp_item,
   output logic                                     rsp_valid,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tsq_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [tsq_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tsq_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                     pready
);

   logic [tsq_pkg::CAP_BITS-1:0] cap_ff;
   logic                         cap_hit;
   tsq_pkg::ctrl_type            ctrl;
   tsq_pkg::status_type          status;

   // configuration register
   assign pready  = 1'b1;
   assign cap_hit = (paddr[tsq_pkg::CSR_ADDR_BITS-1:2] == tsq_pkg::CSR_CAPACITY_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= tsq_pkg::CAP_RESET;
      end else if (psel && penable && pwrite && pready && cap_hit) begin
         cap_ff <= pwdata[tsq_pkg::CAP_BITS-1:0];
      end
   end

   assign prdata = cap_hit ? tsq_pkg::CSR_DATA_BITS'(cap_ff) : '0;

   tsq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctrl   (ctrl)
   );

   tsq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .capacity  (cap_ff),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

endmodule

`default_nettype wire

[sim/tsq_checker.sv]
`timescale 1ns / 1ps

// watches the command, result and register ports of the queue unit, keeps its
// own copy of both stacks and compares every result with the expected one
module tsq_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               busy,
   input  wire tsq_pkg::req_type                   req_item,
   input  wire tsq_pkg::rsp_type                   rsp_item,
   input  wire logic                               rsp_valid,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tsq_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [tsq_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input  wire logic [tsq_pkg::CSR_DATA_BITS-1:0]  prdata,
   input  wire logic                               pready,
   output int                                      error_total,
   output int                                      awaited_total
);
   import tsq_pkg::*;

   // shadow copy of the two stacks and the capacity register
   logic signed [DATA_BITS-1:0] in_words  [MAX_STACK_DEPTH];
   logic signed [DATA_BITS-1:0] out_words [MAX_STACK_DEPTH];
   int unsigned                 in_fill;
   int unsigned                 out_fill;
   logic [CAP_BITS-1:0]         capacity;

   // results still owed by the unit, oldest first
   rsp_type                     owed_results[$];

   initial begin
      error_total   = 0;
      awaited_total = 0;
   end

   // move the whole input stack onto the empty output stack, top first
   function automatic void move_in_to_out();
      while (in_fill > 0 && out_fill < MAX_STACK_DEPTH) begin
         in_fill--;
         out_words[out_fill] = in_words[in_fill];
         out_fill++;
      end
   endfunction

   // apply one command to the shadow stacks and return the result it gives
   function automatic rsp_type apply_command(input req_type cmd);
      int unsigned limit;
      rsp_type     res;
      if (capacity == 0)
         limit = 1;
      else if (capacity > MAX_STACK_DEPTH)
         limit = MAX_STACK_DEPTH;
      else
         limit = capacity;
      res = '0;
      case (cmd.command)
         CMD_ENQUEUE: begin
            // full: input stack at capacity while output stack still holds words
            if (in_fill >= limit && out_fill != 0) begin
               res.error = 1'b1;
            end else begin
               if (in_fill >= limit)
                  move_in_to_out();
               in_words[in_fill] = cmd.push_value;
               in_fill++;
            end
         end
         CMD_DEQUEUE: begin
            if (in_fill == 0 && out_fill == 0) begin
               res.error = 1'b1;
            end else begin
               if (out_fill == 0)
                  move_in_to_out();
               out_fill--;
               res.data_out = out_words[out_fill];
            end
         end
         CMD_READ: begin
            // oldest words sit on top of the output stack, then the input stack from the bottom
            if (cmd.position < out_fill)
               res.data_out = out_words[out_fill - cmd.position - 1];
            else if (cmd.position - out_fill < in_fill)
               res.data_out = in_words[cmd.position - out_fill];
            else
               res.error = 1'b1;
         end
         default: ;
      endcase
      res.element_count = COUNT_BITS'(in_fill + out_fill);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         in_fill  = 0;
         out_fill = 0;
         capacity = CAP_RESET;
         owed_results.delete();
      end else begin
         // compare a shown result with the oldest one owed
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               $error("result with no command outstanding: data_out %0d error %0b count %0d",
                      rsp_item.data_out, rsp_item.error, rsp_item.element_count);
               error_total++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_item.data_out !== want.data_out) begin
                  $error("data_out: expected %0d, got %0d", want.data_out, rsp_item.data_out);
                  error_total++;
               end
               if (rsp_item.error !== want.error) begin
                  $error("error: expected %0b, got %0b", want.error, rsp_item.error);
                  error_total++;
               end
               if (rsp_item.element_count !== want.element_count) begin
                  $error("element_count: expected %0d, got %0d",
                         want.element_count, rsp_item.element_count);
                  error_total++;
               end
            end
         end

         // accepted command item
         if (start && !busy)
            owed_results.push_back(apply_command(req_item));

         // register port: writes update the shadow, reads are checked against it
         if (psel && penable && pready && paddr[CSR_ADDR_BITS-1:2] == CSR_CAPACITY_INDEX) begin
            if (pwrite) begin
               capacity = pwdata[CAP_BITS-1:0];
            end else if (prdata !== CSR_DATA_BITS'(capacity)) begin
               $error("stack_capacity: expected %0d, got %0d", capacity, prdata);
               error_total++;
            end
         end
      end
      awaited_total = owed_results.size();
   end

endmodule

[sim/two_stack_queue_unit_tb.sv]
`timescale 1ns / 1ps

module two_stack_queue_unit_tb;
   import tsq_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 150;

   logic                      clock   = 1'b0;
   logic                      reset   = 1'b1;
   logic                      start   = 1'b0;
   logic                      busy;
   req_type                   req_item = '0;
   rsp_type                   rsp_item;
   logic                      rsp_valid;
   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   int                        error_total;
   int                        awaited_total;
   int                        quiet_cycles = 0;
   int                        sender_idle_pct = 0;
   int                        read_span = 2 * MAX_STACK_DEPTH - 1;

   // capacity per random phase, out of range values included
   int                        phase_cap [PHASES] = '{1, 0, 5, 511, 2, 16, 256, 3, 40};

   always #4 clock = ~clock;

   two_stack_queue_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tsq_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_item      (rsp_item),
      .rsp_valid     (rsp_valid),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .error_total   (error_total),
      .awaited_total (awaited_total)
   );

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** two_stack_queue_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_item(input cmd_type c, input logic [DATA_BITS-1:0] v,
                                         input logic [POS_BITS-1:0] p);
      req_type it;
      it.command    = c;
      it.push_value = v;
      it.position   = p;
      return it;
   endfunction

   // random command, enqueue share set by the caller
   function automatic req_type random_item(input int enq_pct);
      req_type it;
      int      pick;
      pick          = $urandom_range(99);
      it.push_value = $urandom();
      if ($urandom_range(3) == 0)
         it.position = POS_BITS'($urandom_range(2 ** POS_BITS - 1));
      else
         it.position = POS_BITS'($urandom_range(read_span));
      if (pick < enq_pct)
         it.command = CMD_ENQUEUE;
      else if (pick < enq_pct + (100 - enq_pct) / 2)
         it.command = CMD_DEQUEUE;
      else if (pick < 100 - (100 - enq_pct) / 7)
         it.command = CMD_READ;
      else
         it.command = CMD_COUNT;
      return it;
   endfunction

   // present one item from a falling edge; returns at the falling edge after acceptance
   // busy only moves at rising edges, so a low busy here means the next edge accepts
   task automatic send(input req_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_item = it;
      while (busy)
         @(negedge clock);
      @(negedge clock);
   endtask

   // hold off until every owed result has come
   task automatic wait_results();
      start = 1'b0;
      do @(negedge clock); while (awaited_total != 0 || busy);
   endtask

   // write the capacity register while idle, then read it back
   task automatic write_capacity(input int value);
      wait_results();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {CSR_CAPACITY_INDEX, 2'b00};
      pwdata  = CSR_DATA_BITS'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      // keep read positions near the queue size this capacity allows
      if (value == 0)
         read_span = 3;
      else if (value >= MAX_STACK_DEPTH)
         read_span = 2 * MAX_STACK_DEPTH - 1;
      else
         read_span = 2 * value + 1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sender_idle_pct = 23;

      // empty queue at reset capacity
      send(make_item(CMD_DEQUEUE, '0, '0));
      send(make_item(CMD_READ, '1, '0));

      // capacity two: transfer on full input stack, refusal when full, reads both sides
      write_capacity(2);
      send(make_item(CMD_ENQUEUE, 32'h7FFF_FFFF, '1));
      send(make_item(CMD_ENQUEUE, 32'h8000_0000, '0));
      send(make_item(CMD_ENQUEUE, 32'hFFFF_FFFF, '0));
      send(make_item(CMD_ENQUEUE, 32'h0000_0000, '0));
      send(make_item(CMD_ENQUEUE, 32'h0000_0005, '0));
      send(make_item(CMD_READ, '0, 9'd0));
      send(make_item(CMD_READ, '0, 9'd3));
      send(make_item(CMD_READ, '0, 9'd4));
      send(make_item(CMD_READ, '0, 9'd511));
      send(make_item(CMD_COUNT, '0, '0));
      repeat (4) send(make_item(CMD_DEQUEUE, '1, '0));
      send(make_item(CMD_DEQUEUE, '0, '0));

      // capacity lowered below the words already held in the input stack
      write_capacity(3);
      send(make_item(CMD_ENQUEUE, 32'd1, '0));
      send(make_item(CMD_ENQUEUE, 32'd2, '0));
      send(make_item(CMD_ENQUEUE, 32'd3, '0));
      write_capacity(1);
      send(make_item(CMD_ENQUEUE, 32'd4, '0));
      send(make_item(CMD_READ, '0, 9'd3));
      repeat (4) send(make_item(CMD_DEQUEUE, '0, '0));

      // largest transfer: fill the input stack at full capacity, then one more
      write_capacity(MAX_STACK_DEPTH);
      for (int n = 0; n <= MAX_STACK_DEPTH; n++)
         send(make_item(CMD_ENQUEUE, $urandom(), '0));
      repeat (16)
         send(make_item(CMD_READ, '0, POS_BITS'($urandom_range(2 ** POS_BITS - 1))));
      send(make_item(CMD_COUNT, '0, '0));
      repeat (240) send(make_item(CMD_DEQUEUE, '0, '0));

      // random phases: sender idles now and then, then often, then never
      for (int ph = 0; ph < PHASES; ph++) begin
         int enq_pct;
         write_capacity(phase_cap[ph]);
         sender_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 65 : 0;
         enq_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // alternate filling and draining stretches
            if (n % 24 == 0)
               enq_pct = $urandom_range(15, 85);
            if ($urandom_range(149) == 0)
               wait_results();
            send(random_item(enq_pct));
         end
      end

      // let the last results come in
      wait_results();
      repeat (8) @(negedge clock);
      if (error_total == 0 && awaited_total == 0)
         $display("** two_stack_queue_unit: PASSED **");
      else
         $display("** two_stack_queue_unit: FAILED **");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/tsq_pkg.sv
hdl/tsq_ctrl.sv
hdl/tsq_dpath.sv
hdl/two_stack_queue_unit.sv
sim/tsq_checker.sv
sim/two_stack_queue_unit_tb.sv
